>>> design/text_console_writer_defines.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent check helpers; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, geometry and codes of the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STEP = 4;
    localparam int CELLS    = COLS * ROWS;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;
    localparam int ADDR_W = $clog2(CELLS);

    // last index of the row copy and first cell of the bottom row
    localparam int COPY_LAST     = (ROWS - 1) * COLS - 1;
    localparam int FILL_ROW_BASE = (ROWS - 1) * COLS;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    localparam logic [3:0] FG_RESET = 4'h0;
    localparam logic [3:0] BG_RESET = 4'hF;
    localparam logic [CELL_W-1:0] RESET_BLANK = {FG_RESET, BG_RESET, CH_SPACE};

    typedef struct packed {
        logic [1:0]       command;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } t_out_item;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WRITE,
        S_SCROLL,
        S_DRAIN,
        S_FILL,
        S_READ_ADDR,
        S_READ_DATA,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rd_capture;
        logic char_exec;
        logic copy_step;
        logic fill_row_base;
        logic fill_step;
        logic init;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_scroll;
        logic copy_last;
        logic fill_last;
    } t_dp_sts;

endpackage

>>> design/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: decodes items and steps the datapath through writes,
// scroll copy, fills and reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_command,
    input  tcw_pkg::t_dp_sts i_sts,
    output tcw_pkg::t_dp_cmd o_cmd,
    output logic            o_busy,
    output logic            o_result_valid
);

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::S_INIT: begin
                if (i_sts.fill_last) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            tcw_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_command)
                        tcw_pkg::CMD_WRITE: n_state = tcw_pkg::S_WRITE;
                        tcw_pkg::CMD_CLEAR: n_state = tcw_pkg::S_FILL;
                        tcw_pkg::CMD_READ:  n_state = tcw_pkg::S_READ_ADDR;
                        default:            n_state = tcw_pkg::S_DONE;
                    endcase
                end
            end
            tcw_pkg::S_WRITE: begin
                n_state = i_sts.need_scroll ? tcw_pkg::S_SCROLL : tcw_pkg::S_DONE;
            end
            tcw_pkg::S_SCROLL: begin
                if (i_sts.copy_last) begin
                    n_state = tcw_pkg::S_DRAIN;
                end
            end
            tcw_pkg::S_DRAIN:     n_state = tcw_pkg::S_FILL;
            tcw_pkg::S_FILL: begin
                if (i_sts.fill_last) begin
                    n_state = tcw_pkg::S_DONE;
                end
            end
            tcw_pkg::S_READ_ADDR: n_state = tcw_pkg::S_READ_DATA;
            tcw_pkg::S_READ_DATA: n_state = tcw_pkg::S_DONE;
            tcw_pkg::S_DONE:      n_state = tcw_pkg::S_IDLE;
            default:              n_state = tcw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_busy         = 1'b1;
        o_result_valid = 1'b0;
        case (r_state)
            tcw_pkg::S_INIT: begin
                o_cmd.fill_step = 1'b1;
                o_cmd.init      = 1'b1;
            end
            tcw_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            tcw_pkg::S_WRITE:     o_cmd.char_exec     = 1'b1;
            tcw_pkg::S_SCROLL:    o_cmd.copy_step     = 1'b1;
            tcw_pkg::S_DRAIN:     o_cmd.fill_row_base = 1'b1;
            tcw_pkg::S_FILL:      o_cmd.fill_step     = 1'b1;
            tcw_pkg::S_READ_ADDR: o_cmd               = '0;
            tcw_pkg::S_READ_DATA: o_cmd.rd_capture    = 1'b1;
            tcw_pkg::S_DONE:      o_result_valid      = 1'b1;
            default:              o_cmd               = '0;
        endcase
    end

endmodule

>>> design/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell store, cursor, colour registers, sweep counter and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_in_item  i_item,
    input  tcw_pkg::t_dp_cmd   i_cmd,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_index,
    input  logic [3:0]         i_cfg_data,
    output tcw_pkg::t_dp_sts   o_sts,
    output tcw_pkg::t_out_item o_result
);

    localparam int AW = tcw_pkg::ADDR_W;
    localparam int CW = tcw_pkg::COL_W;
    localparam int RW = tcw_pkg::ROW_W;

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];

    tcw_pkg::t_in_item          r_item;
    logic [RW-1:0]              r_row;
    logic [RW-1:0]              n_row;
    logic [CW-1:0]              r_col;
    logic [CW-1:0]              n_col;
    logic [3:0]                 r_fg;
    logic [3:0]                 r_bg;
    logic [tcw_pkg::CELL_W-1:0] r_cell;
    logic [tcw_pkg::CELL_W-1:0] r_rdata;
    logic [AW-1:0]              r_idx;
    logic                       r_wr_pend;
    logic [AW-1:0]              r_wr_addr;

    logic                       is_nl;
    logic                       is_tab;
    logic                       printable;
    logic [CW:0]                col_sum;
    logic                       advance;
    logic                       need_scroll;
    logic [AW-1:0]              cur_addr;
    logic [AW-1:0]              item_addr;
    logic                       in_range;
    logic [AW-1:0]              rd_addr;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [tcw_pkg::CELL_W-1:0] wdata;
    logic [tcw_pkg::CELL_W-1:0] blank;

    // cursor advance for a write-char item
    always_comb begin
        is_nl     = (r_item.char_code == tcw_pkg::CH_NEWLINE);
        is_tab    = (r_item.char_code == tcw_pkg::CH_TAB);
        printable = !is_nl && !is_tab;
        col_sum   = {1'b0, r_col} + (is_tab ? (CW+1)'(tcw_pkg::TAB_STEP) : (CW+1)'(1));
        advance   = 1'b0;
        n_col     = col_sum[CW-1:0];
        if (is_nl) begin
            n_col   = '0;
            advance = 1'b1;
        end else if (col_sum >= (CW+1)'(tcw_pkg::COLS)) begin
            n_col   = '0;
            advance = 1'b1;
        end
        need_scroll = advance && (r_row == RW'(tcw_pkg::ROWS - 1));
        n_row = (advance && !need_scroll) ? r_row + RW'(1) : r_row;
    end

    assign o_sts.need_scroll = need_scroll;

    assign cur_addr  = AW'(AW'(r_row) * AW'(tcw_pkg::COLS)) + AW'(r_col);
    assign in_range  = (r_item.read_row < RW'(tcw_pkg::ROWS)) &&
                       (r_item.read_col < CW'(tcw_pkg::COLS));
    assign item_addr = in_range ?
        AW'(AW'(r_item.read_row) * AW'(tcw_pkg::COLS)) + AW'(r_item.read_col) : '0;

    assign o_sts.copy_last = (r_idx == AW'(tcw_pkg::COPY_LAST));
    assign o_sts.fill_last = (r_idx == AW'(tcw_pkg::CELLS - 1));

    // reset sweep always uses the reset colour, whatever config does meanwhile
    assign blank   = i_cmd.init ? tcw_pkg::RESET_BLANK : {r_fg, r_bg, tcw_pkg::CH_SPACE};
    assign rd_addr = i_cmd.copy_step ? r_idx + AW'(tcw_pkg::COLS) : item_addr;

    // single write port; a pending copy write never overlaps a fill or char write
    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = blank;
        if (r_wr_pend) begin
            we    = 1'b1;
            waddr = r_wr_addr;
            wdata = r_rdata;
        end else if (i_cmd.fill_step) begin
            we = 1'b1;
        end else if (i_cmd.char_exec && printable) begin
            we    = 1'b1;
            waddr = cur_addr;
            wdata = {r_fg, r_bg, r_item.char_code};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_fg      <= tcw_pkg::FG_RESET;
            r_bg      <= tcw_pkg::BG_RESET;
            r_idx     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tcw_pkg::CFG_FG: r_fg <= i_cfg_data;
                    tcw_pkg::CFG_BG: r_bg <= i_cfg_data;
                    default: ;
                endcase
            end
            r_wr_pend <= i_cmd.copy_step;
            if (i_cmd.load) begin
                r_idx <= '0;
                if (i_item.command == tcw_pkg::CMD_CLEAR) begin
                    r_row <= '0;
                    r_col <= '0;
                end
            end else if (i_cmd.char_exec) begin
                r_idx <= '0;
                r_row <= n_row;
                r_col <= n_col;
            end else if (i_cmd.fill_row_base) begin
                r_idx <= AW'(tcw_pkg::FILL_ROW_BASE);
            end else if (i_cmd.copy_step || i_cmd.fill_step) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= r_idx;
        if (i_cmd.load) begin
            r_item <= i_item;
            r_cell <= '0;
        end else if (i_cmd.rd_capture) begin
            r_cell <= in_range ? r_rdata : '0;
        end
    end

    assign o_result.cell_value = r_cell;
    assign o_result.cursor_row = r_row;
    assign o_result.cursor_col = r_col;

endmodule

>>> design/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with cursor, scroll, clear and cell read.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each item gives one
// result on o_result for a single cycle marked by o_result_valid, and the
// receiver cannot stall it, so capture it when the strobe is high. The
// single-port cell store is walked one cell per cycle. A character, newline
// or tab passes the write state, a read the address and data states, a clear
// a fill of every cell, and a write that scrolls a copy of the rows up, a drain
// and a fill of the bottom row, each then the result. After reset the store is
// swept to blanks with busy high; configuration writes are taken at any time
// (o_cfg_ready is always high) but should only be made while busy is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module text_console_writer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tcw_pkg::t_in_item  i_item,
    output logic               o_result_valid,
    output tcw_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [3:0]         i_cfg_data
);

    tcw_pkg::t_dp_cmd dp_cmd;
    tcw_pkg::t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_command      (i_item.command),
        .i_sts          (dp_sts),
        .o_cmd          (dp_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    tcw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (dp_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (dp_sts),
        .o_result    (o_result)
    );

    `TCW_ASSERT_IMP(a_result_while_busy, i_clk, i_rst_n, o_result_valid, busy, "result strobe outside an item")
    `TCW_ASSERT_NXT(a_accept_then_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised after accept")
    `TCW_ASSERT_NXT(a_result_then_idle, i_clk, i_rst_n, o_result_valid, !busy && !o_result_valid, "no return to idle after result")
    `TCW_ASSERT_IMP(a_cursor_in_range, i_clk, i_rst_n, o_result_valid, (o_result.cursor_col < tcw_pkg::COLS) && (o_result.cursor_row < tcw_pkg::ROWS), "cursor out of range")

endmodule

>>> tb/sv/tb_text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console: a shadow screen and cursor predict
// every result, covering printing, tab and newline, column wrap, scroll,
// clear, cell reads in and out of range, and colour register changes.
// ----------------------------------------------------------------------------

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;   // unused code, must leave state alone
    localparam longint CYCLE_LIMIT  = 6_000_000;
    localparam int     DRAIN_CYCLES = 2100;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_in_item   i_item      = '0;
    logic       o_result_valid;
    t_out_item  o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = CFG_FG;
    logic [3:0] i_cfg_data  = 4'h0;

    text_console_writer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // shadow copy of the console
    logic [CELL_W-1:0] shadow_cells [CELLS];
    int unsigned       shadow_row;
    int unsigned       shadow_col;
    logic [3:0]        shadow_fg;
    logic [3:0]        shadow_bg;
    t_out_item         console_outputs [$];

    int unsigned send_idle_pct = 19;
    int unsigned n_items    = 0;
    int unsigned n_reads    = 0;
    int unsigned n_clears   = 0;
    int unsigned n_scrolls  = 0;
    int unsigned n_settings = 0;
    int unsigned err_count  = 0;
    longint      cycle_count = 0;

    always #2 i_clk = ~i_clk;

    function automatic logic [CELL_W-1:0] blank_cell();
        return {shadow_fg, shadow_bg, CH_SPACE};
    endfunction

    function automatic void fill_blank();
        foreach (shadow_cells[i]) shadow_cells[i] = blank_cell();
    endfunction

    function automatic void scroll_shadow();
        for (int i = 0; i < (ROWS - 1) * COLS; i++)
            shadow_cells[i] = shadow_cells[i + COLS];
        for (int c = 0; c < COLS; c++)
            shadow_cells[(ROWS - 1) * COLS + c] = blank_cell();
        n_scrolls++;
    endfunction

    // applies one item to the shadow console and returns the expected result
    function automatic t_out_item console_step(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.command)
            CMD_WRITE: begin
                if (it.char_code == CH_NEWLINE) begin
                    shadow_row++;
                    shadow_col = 0;
                end else if (it.char_code == CH_TAB) begin
                    shadow_col += TAB_STEP;
                end else begin
                    shadow_cells[shadow_row * COLS + shadow_col] =
                        {shadow_fg, shadow_bg, it.char_code};
                    shadow_col++;
                end
                if (shadow_col >= COLS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                if (shadow_row >= ROWS) begin
                    scroll_shadow();
                    shadow_row = ROWS - 1;
                end
            end
            CMD_CLEAR: begin
                fill_blank();
                shadow_row = 0;
                shadow_col = 0;
                n_clears++;
            end
            CMD_READ: begin
                n_reads++;
                if (it.read_row < ROWS && it.read_col < COLS)
                    r.cell_value = shadow_cells[it.read_row * COLS + it.read_col];
            end
            default: ;
        endcase
        r.cursor_row = shadow_row[ROW_W-1:0];
        r.cursor_col = shadow_col[COL_W-1:0];
        return r;
    endfunction

    function automatic t_in_item make_item(logic [1:0] cmd, logic [7:0] ch,
                                           logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        t_in_item it;
        it.command   = cmd;
        it.char_code = ch;
        it.read_row  = row;
        it.read_col  = col;
        return it;
    endfunction

    // any byte that prints, i.e. neither tab nor newline
    function automatic logic [7:0] random_glyph();
        logic [7:0] ch;
        ch = 8'($urandom_range(255));
        if (ch == CH_TAB || ch == CH_NEWLINE)
            ch = CH_SPACE;
        return ch;
    endfunction

    // start stays high after acceptance; it drops only in a gap or in wait_idle
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        console_outputs.push_back(console_step(it));
        n_items++;
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_item(make_item(CMD_WRITE, ch, ROW_W'($urandom_range(31)),
                            COL_W'($urandom_range(127))));
    endtask

    task automatic read_cell(input int unsigned row, input int unsigned col);
        send_item(make_item(CMD_READ, 8'($urandom_range(255)), ROW_W'(row), COL_W'(col)));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (console_outputs.size() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic set_colours(input logic [3:0] fg, input logic [3:0] bg);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_FG;
        i_cfg_data  <= fg;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_fg = fg;
        i_cfg_index <= CFG_BG;
        i_cfg_data  <= bg;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_bg = bg;
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic test_reset_state();
        read_cell(0, 0);
        read_cell(ROWS - 1, COLS - 1);
        send_item(make_item(CMD_NOP, 8'hFF, '1, '1));
    endtask

    task automatic test_char_extremes();
        put_char(8'h00);
        put_char(8'hFF);
        send_item(make_item(CMD_WRITE, 8'h41, '1, '1));
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(0, 2);
    endtask

    task automatic test_control_chars();
        put_char(CH_TAB);
        put_char(CH_NEWLINE);
        read_cell(ROWS, 0);
        read_cell(0, COLS);
        send_item(make_item(CMD_READ, 8'h00, '1, '1));
    endtask

    // older cells keep the colour they were written with
    task automatic test_colour_change();
        set_colours(4'hF, 4'h0);
        put_char(8'h5A);
        read_cell(shadow_row, shadow_col - 1);
        read_cell(0, 0);
    endtask

    task automatic test_clear();
        send_item(make_item(CMD_CLEAR, 8'($urandom_range(255)), ROW_W'($urandom_range(31)),
                            COL_W'($urandom_range(127))));
        read_cell(0, 0);
        read_cell(ROWS - 1, COLS - 1);
    endtask

    task automatic test_wrap_and_scroll();
        repeat (COLS - 1) put_char(random_glyph());
        put_char(random_glyph());          // last column, wraps
        read_cell(0, COLS - 1);
        repeat (COLS - 2) put_char(random_glyph());
        put_char(CH_TAB);                  // crosses the edge, lands on column 0
        while (shadow_row < ROWS - 1) put_char(CH_NEWLINE);
        repeat (5) put_char(random_glyph());
        put_char(CH_NEWLINE);              // newline on bottom row scrolls
        read_cell(ROWS - 2, 0);
        read_cell(ROWS - 1, 0);
        repeat (COLS) put_char(random_glyph());   // wrap on bottom row scrolls
        read_cell(ROWS - 2, COLS - 1);
        read_cell(ROWS - 1, 0);
    endtask

    task automatic test_random_traffic(input int unsigned n, input int unsigned idle_pct);
        t_in_item    it;
        int unsigned goal;
        int unsigned pick;
        send_idle_pct = idle_pct;
        goal = n_items + n;
        while (n_items < goal) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                it = make_item(CMD_WRITE, 8'($urandom_range(255)),
                               ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
                pick = $urandom_range(199);
                if (pick >= 90 && pick < 102) begin
                    it.char_code = CH_NEWLINE;
                end else if (pick >= 102 && pick < 112) begin
                    it.char_code = CH_TAB;
                end else if (pick >= 112 && pick < 114) begin
                    it.command = CMD_CLEAR;
                end else if (pick >= 114 && pick < 120) begin
                    it.command = CMD_NOP;
                end else if (pick >= 120) begin
                    it.command = CMD_READ;
                    if (pick < 160) begin
                        // cell just behind the cursor, or the row's last cell at column 0
                        it.read_row = ROW_W'(shadow_row);
                        it.read_col = COL_W'((shadow_col == 0) ? COLS - 1 : shadow_col - 1);
                    end else if (pick < 188) begin
                        it.read_row = ROW_W'($urandom_range(ROWS - 1));
                        it.read_col = COL_W'($urandom_range(COLS - 1));
                    end
                    // otherwise full field range, mostly out of bounds
                end
                send_item(it);
            end else if (pick < 68) begin
                repeat ($urandom_range(100, 1)) put_char(random_glyph());
                if ($urandom_range(9) < 7)
                    put_char(CH_NEWLINE);
            end else if (pick < 84) begin
                repeat ($urandom_range(4, 1)) read_cell(shadow_row, $urandom_range(COLS - 1));
            end else if (pick < 94) begin
                repeat ($urandom_range(25, 1)) put_char(CH_TAB);
            end else begin
                repeat ($urandom_range(30, 1)) put_char(CH_NEWLINE);
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_result_valid) begin
            if (console_outputs.size() == 0) begin
                $error("result with nothing pending: %p", o_result);
                err_count++;
            end else begin
                want = console_outputs.pop_front();
                if (o_result.cell_value !== want.cell_value) begin
                    $error("cell_value: expected %h, got %h",
                           want.cell_value, o_result.cell_value);
                    err_count++;
                end
                if (o_result.cursor_row !== want.cursor_row) begin
                    $error("cursor_row: expected %0d, got %0d",
                           want.cursor_row, o_result.cursor_row);
                    err_count++;
                end
                if (o_result.cursor_col !== want.cursor_col) begin
                    $error("cursor_col: expected %0d, got %0d",
                           want.cursor_col, o_result.cursor_col);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        shadow_fg  = FG_RESET;
        shadow_bg  = BG_RESET;
        shadow_row = 0;
        shadow_col = 0;
        fill_blank();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_char_extremes();
        test_control_chars();
        test_colour_change();
        test_clear();
        test_wrap_and_scroll();

        set_colours(4'h0, 4'h0);
        test_random_traffic(60, 19);
        set_colours(4'hF, 4'hF);
        test_random_traffic(60, 59);
        set_colours(4'($urandom_range(15)), 4'($urandom_range(15)));
        test_random_traffic(60, 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d items, %0d reads, %0d clears, %0d scrolls, %0d colour settings",
                 n_items, n_reads, n_clears, n_scrolls, n_settings);
        $display("summary: %0d mismatches, %0d cycles", err_count, cycle_count);
        if (err_count == 0 && console_outputs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
